@@ rtl/bmc_pkg.sv @@
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared types and codes for the button multi-click detector: state codes,
// event codes, register indexes, the configuration bundle and the result.
// ----------------------------------------------------------------------------
package bmc_pkg;

    localparam int TIME_W = 32;
    localparam int MS_W   = 16;
    localparam int EV_W   = 3;
    localparam int ST_W   = 3;
    localparam int CNT_W  = 2;
    localparam int IDX_W  = 3;

    localparam logic [ST_W-1:0] ST_IDLE        = 3'd0;
    localparam logic [ST_W-1:0] ST_PRESSED     = 3'd1;
    localparam logic [ST_W-1:0] ST_WAIT_DOUBLE = 3'd2;
    localparam logic [ST_W-1:0] ST_WAIT_TRIPLE = 3'd3;
    localparam logic [ST_W-1:0] ST_HELD        = 3'd4;

    localparam logic [EV_W-1:0] EV_NONE    = 3'd0;
    localparam logic [EV_W-1:0] EV_CLICK   = 3'd1;
    localparam logic [EV_W-1:0] EV_DOUBLE  = 3'd2;
    localparam logic [EV_W-1:0] EV_TRIPLE  = 3'd3;
    localparam logic [EV_W-1:0] EV_HOLD    = 3'd4;
    localparam logic [EV_W-1:0] EV_RELEASE = 3'd5;

    localparam logic [CNT_W-1:0] TRIPLE_COUNT = 2'd3;
    localparam logic [CNT_W-1:0] DOUBLE_COUNT = 2'd2;

    localparam logic [IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_CLICK_MAX = 3'd2;
    localparam logic [IDX_W-1:0] REG_HOLD      = 3'd3;
    localparam logic [IDX_W-1:0] REG_GAP       = 3'd4;

    localparam logic [MS_W-1:0] DEBOUNCE_RST  = 16'd20;
    localparam logic [MS_W-1:0] CLICK_MAX_RST = 16'd300;
    localparam logic [MS_W-1:0] HOLD_RST      = 16'd1000;
    localparam logic [MS_W-1:0] GAP_RST       = 16'd300;

    typedef struct packed {
        logic            enable;
        logic [MS_W-1:0] debounce_ms;
        logic [MS_W-1:0] click_max_ms;
        logic [MS_W-1:0] hold_ms;
        logic [MS_W-1:0] multi_click_gap_ms;
    } bmc_cfg_t;

    typedef struct packed {
        logic [EV_W-1:0]   event_code;
        logic              is_pressed;
        logic [TIME_W-1:0] held_time_ms;
    } bmc_result_t;

endpackage

@@ rtl/bmc_core.sv @@
// ----------------------------------------------------------------------------
// bmc_core
// Debounce and click state machine. Computes the result of one poll from the
// current state and commits the new state when step is high.
// ----------------------------------------------------------------------------
module bmc_core
    import bmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              pin_level,
    input  logic [TIME_W-1:0] now_ms,
    input  bmc_cfg_t          cfg,
    output bmc_result_t       result
);

    logic [ST_W-1:0]   state_reg,   state_next;
    logic [TIME_W-1:0] press_reg,   press_next;
    logic [TIME_W-1:0] release_reg, release_next;
    logic              level_reg,   level_next;
    logic [TIME_W-1:0] change_reg,  change_next;
    logic              fired_reg,   fired_next;
    logic [CNT_W-1:0]  clicks_reg,  clicks_next;

    logic              raw;
    logic              pressed;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] gap;
    logic [CNT_W-1:0]  clicks_inc;
    logic [EV_W-1:0]   event_code;

    always_comb
    begin
        raw          = ~pin_level;
        since_change = now_ms - change_reg;
        held         = now_ms - press_reg;
        gap          = now_ms - release_reg;
        clicks_inc   = clicks_reg + 2'd1;

        level_next   = level_reg;
        change_next  = change_reg;
        state_next   = state_reg;
        press_next   = press_reg;
        release_next = release_reg;
        fired_next   = fired_reg;
        clicks_next  = clicks_reg;
        event_code   = EV_NONE;
        pressed      = 1'b0;

        if (cfg.enable)
        begin
            if ((raw != level_reg) && (since_change >= {16'd0, cfg.debounce_ms}))
            begin
                level_next  = raw;
                change_next = now_ms;
            end
            pressed = level_next;
        end

        unique case (state_reg)
            ST_PRESSED:
            begin
                if (!pressed)
                begin
                    release_next = now_ms;
                    if (held < {16'd0, cfg.click_max_ms})
                    begin
                        clicks_next = clicks_inc;
                        if (clicks_inc >= TRIPLE_COUNT)
                        begin
                            event_code  = EV_TRIPLE;
                            clicks_next = '0;
                            state_next  = ST_IDLE;
                        end
                        else if (clicks_inc == DOUBLE_COUNT)
                        begin
                            state_next = ST_WAIT_TRIPLE;
                        end
                        else
                        begin
                            state_next = ST_WAIT_DOUBLE;
                        end
                    end
                    else
                    begin
                        clicks_next = '0;
                        state_next  = ST_IDLE;
                        if (fired_reg)
                        begin
                            event_code = EV_RELEASE;
                        end
                    end
                end
                else if ((held >= {16'd0, cfg.hold_ms}) && !fired_reg)
                begin
                    fired_next  = 1'b1;
                    clicks_next = '0;
                    state_next  = ST_HELD;
                    event_code  = EV_HOLD;
                end
            end
            ST_WAIT_DOUBLE, ST_WAIT_TRIPLE:
            begin
                if (pressed)
                begin
                    press_next = now_ms;
                    fired_next = 1'b0;
                    state_next = ST_PRESSED;
                end
                else if (gap >= {16'd0, cfg.multi_click_gap_ms})
                begin
                    event_code  = (state_reg == ST_WAIT_DOUBLE) ? EV_CLICK : EV_DOUBLE;
                    clicks_next = '0;
                    state_next  = ST_IDLE;
                end
            end
            ST_HELD:
            begin
                if (!pressed)
                begin
                    event_code  = EV_RELEASE;
                    clicks_next = '0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                if (pressed)
                begin
                    clicks_next = '0;
                    press_next  = now_ms;
                    fired_next  = 1'b0;
                    state_next  = ST_PRESSED;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase

        result.event_code   = event_code;
        result.is_pressed   = pressed;
        result.held_time_ms = ((state_next == ST_PRESSED) || (state_next == ST_HELD))
                              ? (now_ms - press_next) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            press_reg   <= '0;
            release_reg <= '0;
            level_reg   <= 1'b0;
            change_reg  <= '0;
            fired_reg   <= 1'b0;
            clicks_reg  <= '0;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            level_reg   <= level_next;
            change_reg  <= change_next;
            fired_reg   <= fired_next;
            clicks_reg  <= clicks_next;
        end
    end

endmodule

@@ rtl/button_multi_click_detector.sv @@
// ----------------------------------------------------------------------------
// button_multi_click_detector
// Debounced active-low button poller reporting click, double, triple, hold
// and release events, one result item per poll item.
// ----------------------------------------------------------------------------
// Each poll item (pin level plus a 32-bit millisecond timestamp) gives exactly
// one result item. The block takes one item per cycle while the result is not
// stalled. An accepted item waits in the input register, where the debounce
// and state update run in a single pass; its result is written to the result
// register as that state is committed, once the result register is free. The
// rate is set by that single state update stage, which commits the state of one
// poll per cycle. A stalled result holds the input register and stalls the
// input. Configuration writes are always ready and are meant for idle periods;
// register indexes above four are ignored.
// ----------------------------------------------------------------------------
module button_multi_click_detector
    import bmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              pin_level,
    input  logic [TIME_W-1:0] now_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [EV_W-1:0]   event_code,
    output logic              is_pressed,
    output logic [TIME_W-1:0] held_time_ms,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [MS_W-1:0]   cfg_data
);

    bmc_cfg_t          cfg_reg;
    logic              in_valid_reg;
    logic              pin_reg;
    logic [TIME_W-1:0] now_reg;
    logic              out_valid_reg;
    bmc_result_t       out_reg;
    bmc_result_t       result;
    logic              out_open;
    logic              advance;
    logic              in_take;

    assign cfg_ready = 1'b1;
    assign out_open  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_open;
    assign in_stall  = in_valid_reg && !out_open;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable             <= 1'b1;
            cfg_reg.debounce_ms        <= DEBOUNCE_RST;
            cfg_reg.click_max_ms       <= CLICK_MAX_RST;
            cfg_reg.hold_ms            <= HOLD_RST;
            cfg_reg.multi_click_gap_ms <= GAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ENABLE:    cfg_reg.enable             <= cfg_data[0];
                REG_DEBOUNCE:  cfg_reg.debounce_ms        <= cfg_data;
                REG_CLICK_MAX: cfg_reg.click_max_ms       <= cfg_data;
                REG_HOLD:      cfg_reg.hold_ms            <= cfg_data;
                REG_GAP:       cfg_reg.multi_click_gap_ms <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pin_reg <= pin_level;
            now_reg <= now_ms;
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    bmc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .pin_level (pin_reg),
        .now_ms    (now_reg),
        .cfg       (cfg_reg),
        .result    (result)
    );

    assign out_valid    = out_valid_reg;
    assign event_code   = out_reg.event_code;
    assign is_pressed   = out_reg.is_pressed;
    assign held_time_ms = out_reg.held_time_ms;

    a_hold_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_code == EV_HOLD)) |-> is_pressed)
        else $error("hold event with button released");

    a_release_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((event_code == EV_RELEASE) || (event_code == EV_CLICK)
            || (event_code == EV_DOUBLE) || (event_code == EV_TRIPLE))) |-> !is_pressed)
        else $error("release or click event with button pressed");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_code <= EV_RELEASE))
        else $error("event code out of range");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("advanced item missing from result register");

endmodule

@@ sim/button_multi_click_detector_tb.sv @@
// ----------------------------------------------------------------------------
// button_multi_click_detector_tb
// Self-checking bench for the debounced button click detector. A short
// directed run with reset thresholds walks through debounce lockout, click,
// double, triple, hold, release, long press and timestamp wrap. Random
// phases then retune the thresholds (small, zero, maximum, random, disabled)
// and send press/release gestures with bounce glitches and time jumps. Each
// accepted poll is run through a local copy of the detector state, and every
// result item is checked field by field against the oldest prediction. Both
// handshakes see random idle bursts except in the maximum and closing phases.
// ----------------------------------------------------------------------------
module button_multi_click_detector_tb
    import bmc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT  = 1000;
    localparam int unsigned PHASE_POLLS  = 40;
    localparam int unsigned FINAL_POLLS  = 30;
    localparam int unsigned TAIL_CYCLES  = 8;
    localparam int unsigned PRINT_LIMIT  = 100;
    localparam logic        PIN_DOWN     = 1'b0;
    localparam logic        PIN_UP       = 1'b1;
    localparam logic [IDX_W-1:0] REG_SPARE_LO = REG_GAP + 3'd1;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic              pin;
        logic [TIME_W-1:0] stamp;
    } poll_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [MS_W-1:0]  data;
    } reg_write_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              pin_level = PIN_UP;
    logic [TIME_W-1:0] now_ms = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [EV_W-1:0]   event_code;
    logic              is_pressed;
    logic [TIME_W-1:0] held_time_ms;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [MS_W-1:0]   cfg_data = '0;

    poll_t       poll_queue[$];
    reg_write_t  reg_writes[$];
    bmc_result_t expected_events[$];

    // detector copy
    bmc_cfg_t          cfg_model;
    logic [ST_W-1:0]   fsm_copy;
    logic [TIME_W-1:0] press_t;
    logic [TIME_W-1:0] rel_t;
    logic [TIME_W-1:0] chg_t;
    logic              db_level;
    logic              hold_done;
    logic [CNT_W-1:0]  clicks;

    bmc_cfg_t          plan;
    logic [TIME_W-1:0] clock_ms = '0;
    int unsigned       polls_planned = 0;
    int unsigned       progress = 0;
    int unsigned       mismatch_count = 0;
    int unsigned       in_gap = 0;
    int unsigned       stall_left = 0;
    bit                idle_en = 1'b1;

    button_multi_click_detector uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pin_level    (pin_level),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_code   (event_code),
        .is_pressed   (is_pressed),
        .held_time_ms (held_time_ms),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        cfg_model = '{enable: 1'b1, debounce_ms: DEBOUNCE_RST, click_max_ms: CLICK_MAX_RST,
                      hold_ms: HOLD_RST, multi_click_gap_ms: GAP_RST};
        plan      = cfg_model;
        fsm_copy  = ST_IDLE;
        press_t   = '0;
        rel_t     = '0;
        chg_t     = '0;
        db_level  = 1'b0;
        hold_done = 1'b0;
        clicks    = '0;
    end

    function automatic void apply_reg(input logic [IDX_W-1:0] idx, input logic [MS_W-1:0] data);
        case (idx)
            REG_ENABLE:    cfg_model.enable = data[0];
            REG_DEBOUNCE:  cfg_model.debounce_ms = data;
            REG_CLICK_MAX: cfg_model.click_max_ms = data;
            REG_HOLD:      cfg_model.hold_ms = data;
            REG_GAP:       cfg_model.multi_click_gap_ms = data;
            default:       ;
        endcase
    endfunction

    function automatic bmc_result_t track_poll(input logic pin, input logic [TIME_W-1:0] now);
        logic              raw;
        logic              down;
        logic [TIME_W-1:0] since;
        logic [TIME_W-1:0] held;
        bmc_result_t       r;
        raw  = ~pin;
        down = 1'b0;
        r    = '0;
        r.event_code = EV_NONE;
        if (cfg_model.enable)
        begin
            since = now - chg_t;
            if (raw != db_level && since >= TIME_W'(cfg_model.debounce_ms))
            begin
                db_level = raw;
                chg_t    = now;
            end
            down = db_level;
        end
        case (fsm_copy)
            ST_PRESSED:
            begin
                held = now - press_t;
                if (!down)
                begin
                    rel_t = now;
                    if (held < TIME_W'(cfg_model.click_max_ms))
                    begin
                        clicks = clicks + 2'd1;
                        if (clicks >= TRIPLE_COUNT)
                        begin
                            r.event_code = EV_TRIPLE;
                            clicks       = '0;
                            fsm_copy     = ST_IDLE;
                        end
                        else if (clicks == DOUBLE_COUNT)
                            fsm_copy = ST_WAIT_TRIPLE;
                        else
                            fsm_copy = ST_WAIT_DOUBLE;
                    end
                    else
                    begin
                        clicks   = '0;
                        fsm_copy = ST_IDLE;
                        if (hold_done)
                            r.event_code = EV_RELEASE;
                    end
                end
                else if (held >= TIME_W'(cfg_model.hold_ms) && !hold_done)
                begin
                    hold_done    = 1'b1;
                    clicks       = '0;
                    fsm_copy     = ST_HELD;
                    r.event_code = EV_HOLD;
                end
            end
            ST_WAIT_DOUBLE, ST_WAIT_TRIPLE:
            begin
                since = now - rel_t;
                if (down)
                begin
                    press_t   = now;
                    hold_done = 1'b0;
                    fsm_copy  = ST_PRESSED;
                end
                else if (since >= TIME_W'(cfg_model.multi_click_gap_ms))
                begin
                    r.event_code = (fsm_copy == ST_WAIT_DOUBLE) ? EV_CLICK : EV_DOUBLE;
                    clicks       = '0;
                    fsm_copy     = ST_IDLE;
                end
            end
            ST_HELD:
            begin
                if (!down)
                begin
                    r.event_code = EV_RELEASE;
                    clicks       = '0;
                    fsm_copy     = ST_IDLE;
                end
            end
            default:
            begin
                if (down)
                begin
                    clicks    = '0;
                    press_t   = now;
                    hold_done = 1'b0;
                    fsm_copy  = ST_PRESSED;
                end
                else
                    fsm_copy = ST_IDLE;
            end
        endcase
        r.is_pressed = down;
        if (fsm_copy == ST_PRESSED || fsm_copy == ST_HELD)
            r.held_time_ms = now - press_t;
        else
            r.held_time_ms = '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH %0t %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin : cfg_port
        reg_write_t w;
        if (cfg_valid && cfg_ready)
        begin
            apply_reg(cfg_index, cfg_data);
            progress++;
        end
        if (!cfg_valid || cfg_ready)
        begin
            if (rst_n && reg_writes.size() != 0)
            begin
                w = reg_writes.pop_front();
                cfg_valid <= 1'b1;
                cfg_index <= w.idx;
                cfg_data  <= w.data;
            end
            else
                cfg_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : poll_driver
        poll_t p;
        if (in_valid && !in_stall)
        begin
            expected_events.push_back(track_poll(pin_level, now_ms));
            progress++;
        end
        if (!in_valid || !in_stall)
        begin
            if (in_gap != 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (rst_n && poll_queue.size() != 0)
            begin
                p = poll_queue.pop_front();
                in_valid  <= 1'b1;
                pin_level <= p.pin;
                now_ms    <= p.stamp;
                if (idle_en && $urandom_range(0, 7) == 0)
                    in_gap = $urandom_range(1, 7);
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        bmc_result_t want;
        if (out_valid && !out_stall)
        begin
            progress++;
            if (expected_events.size() == 0)
                report_mismatch("result with nothing pending", TIME_W'(event_code),
                                TIME_W'(EV_NONE));
            else
            begin
                want = expected_events.pop_front();
                if (event_code !== want.event_code)
                    report_mismatch("event_code", TIME_W'(event_code),
                                    TIME_W'(want.event_code));
                if (is_pressed !== want.is_pressed)
                    report_mismatch("is_pressed", TIME_W'(is_pressed),
                                    TIME_W'(want.is_pressed));
                if (held_time_ms !== want.held_time_ms)
                    report_mismatch("held_time_ms", held_time_ms, want.held_time_ms);
            end
        end
        if (stall_left == 0 && idle_en && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 7);
        out_stall <= (stall_left != 0);
        if (stall_left != 0)
            stall_left--;
    end

    initial
    begin : watchdog
        int unsigned last_progress;
        int unsigned quiet_cycles;
        last_progress = 0;
        quiet_cycles  = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(negedge clk);
            if (progress != last_progress)
            begin
                last_progress = progress;
                quiet_cycles  = 0;
            end
            else
                quiet_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic push_poll(input logic pin, input logic [TIME_W-1:0] stamp);
        poll_queue.push_back('{pin: pin, stamp: stamp});
        clock_ms = stamp;
        polls_planned++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (poll_queue.size() != 0 || in_valid || expected_events.size() != 0 ||
               reg_writes.size() != 0 || cfg_valid);
    endtask

    // hold one level for a span of ms, with the odd bounce glitch
    task automatic add_span(input logic level, input int unsigned span, input int unsigned stride);
        int unsigned elapsed;
        int unsigned dt;
        logic        glitch;
        elapsed = 0;
        do
        begin
            dt      = $urandom_range(1, stride);
            elapsed = elapsed + dt;
            glitch  = ($urandom_range(0, 9) == 0);
            push_poll(level ^ glitch, clock_ms + dt);
        end
        while (elapsed < span);
    endtask

    task automatic add_gesture(input int unsigned stride);
        int unsigned press_len;
        int unsigned gap_len;
        case ($urandom_range(0, 3))
            0, 1:    press_len = $urandom_range(0, plan.click_max_ms);
            2:       press_len = $urandom_range(plan.click_max_ms, plan.hold_ms);
            default: press_len = plan.hold_ms + $urandom_range(0, plan.hold_ms / 2 + 1);
        endcase
        if ($urandom_range(0, 2) != 0)
            gap_len = $urandom_range(0, plan.multi_click_gap_ms);
        else
            gap_len = plan.multi_click_gap_ms + $urandom_range(0, plan.multi_click_gap_ms / 2 + 1);
        add_span(PIN_DOWN, press_len, stride);
        add_span(PIN_UP, gap_len, stride);
    endtask

    task automatic program_config(input bmc_cfg_t c);
        logic [MS_W-1:0] en_word;
        en_word = MS_W'($urandom());
        en_word[0] = c.enable;
        reg_writes.push_back('{idx: REG_ENABLE, data: en_word});
        reg_writes.push_back('{idx: REG_DEBOUNCE, data: c.debounce_ms});
        reg_writes.push_back('{idx: REG_CLICK_MAX, data: c.click_max_ms});
        reg_writes.push_back('{idx: REG_HOLD, data: c.hold_ms});
        reg_writes.push_back('{idx: REG_GAP, data: c.multi_click_gap_ms});
        reg_writes.push_back('{idx: REG_SPARE_LO, data: MS_W'($urandom())});
        reg_writes.push_back('{idx: REG_SPARE_HI, data: MS_W'($urandom())});
        plan = c;
        wait_drained();
    endtask

    task automatic run_phase(input bmc_cfg_t c, input int unsigned budget, input bit idle);
        int unsigned stride;
        int unsigned start;
        program_config(c);
        idle_en = idle;
        stride  = c.click_max_ms;
        if (c.hold_ms > stride)
            stride = c.hold_ms;
        if (c.multi_click_gap_ms > stride)
            stride = c.multi_click_gap_ms;
        stride = stride / 10 + 1;
        start  = polls_planned;
        while (polls_planned - start < budget)
        begin
            if ($urandom_range(0, 11) == 0)
                repeat ($urandom_range(1, 3))
                    push_poll($urandom_range(0, 1) != 0, $urandom());
            else
                add_gesture(stride);
        end
        // leave a hold or a pending click open across the next retune
        case ($urandom_range(0, 2))
            0:
                add_span(PIN_DOWN, c.hold_ms + stride, stride);
            1:
            begin
                add_span(PIN_DOWN, $urandom_range(0, c.click_max_ms), stride);
                push_poll(PIN_UP, clock_ms + TIME_W'(c.debounce_ms));
            end
            default: ;
        endcase
        wait_drained();
    endtask

    initial
    begin : stimulus
        bmc_cfg_t c;
        bmc_cfg_t tight;
        tight = '{enable: 1'b1, debounce_ms: 16'd2, click_max_ms: 16'd20, hold_ms: 16'd60,
                  multi_click_gap_ms: 16'd25};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset thresholds: lockout from time zero, then each gesture once
        push_poll(PIN_DOWN, 32'd5);
        push_poll(PIN_DOWN, 32'd25);
        push_poll(PIN_UP, 32'd30);
        push_poll(PIN_UP, 32'd100);
        push_poll(PIN_UP, 32'd450);
        push_poll(PIN_DOWN, 32'd500);
        push_poll(PIN_UP, 32'd550);
        push_poll(PIN_DOWN, 32'd600);
        push_poll(PIN_UP, 32'd650);
        push_poll(PIN_UP, 32'd1000);
        push_poll(PIN_DOWN, 32'd1050);
        push_poll(PIN_UP, 32'd1100);
        push_poll(PIN_DOWN, 32'd1150);
        push_poll(PIN_UP, 32'd1200);
        push_poll(PIN_DOWN, 32'd1250);
        push_poll(PIN_UP, 32'd1300);
        push_poll(PIN_DOWN, 32'd1400);
        push_poll(PIN_DOWN, 32'd2400);
        push_poll(PIN_UP, 32'd2500);
        push_poll(PIN_DOWN, 32'd2600);
        push_poll(PIN_UP, 32'd3000);
        push_poll(PIN_DOWN, 32'hFFFF_FFF0);
        push_poll(PIN_UP, 32'h0000_0010);
        push_poll(PIN_UP, 32'h0000_0200);
        push_poll(PIN_DOWN, 32'hFFFF_FFFF);
        wait_drained();

        run_phase(tight, PHASE_POLLS, 1'b1);
        c = tight;
        c.enable = 1'b0;
        run_phase(c, PHASE_POLLS, 1'b1);
        c = '{enable: 1'b1, debounce_ms: 16'hFFFF, click_max_ms: 16'hFFFF, hold_ms: 16'hFFFF,
              multi_click_gap_ms: 16'hFFFF};
        run_phase(c, PHASE_POLLS, 1'b0);
        c = '{enable: 1'b1, debounce_ms: 16'd0, click_max_ms: 16'd0, hold_ms: 16'd0,
              multi_click_gap_ms: 16'd0};
        run_phase(c, PHASE_POLLS, 1'b1);
        repeat (3)
        begin
            c.enable             = ($urandom_range(0, 3) != 0);
            c.debounce_ms        = MS_W'($urandom_range(0, 40));
            c.click_max_ms       = MS_W'($urandom_range(0, 200));
            c.hold_ms            = MS_W'($urandom_range(0, 400));
            c.multi_click_gap_ms = MS_W'($urandom_range(0, 200));
            run_phase(c, PHASE_POLLS, 1'b1);
        end

        run_phase(tight, FINAL_POLLS, 1'b0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
